FILE: rtl/drc_pkg.sv
package drc_pkg;

   localparam int EdgeWidth = 18;
   localparam int FieldWidth = 15;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_FULL  = 2'd1,
      FUNC_EMIT  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PASS_START,
      ST_RD_I,
      ST_LAT_I,
      ST_RD_J,
      ST_CMP,
      ST_RD_LAST,
      ST_WR_LAST,
      ST_CLIP_RD,
      ST_CLIP_CHK,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EMPTY_OUT
   } state_type;

   typedef struct packed {
      logic signed [EdgeWidth-1:0] x0;
      logic signed [EdgeWidth-1:0] y0;
      logic signed [EdgeWidth-1:0] x1;
      logic signed [EdgeWidth-1:0] y1;
   } box_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

endpackage

FILE: rtl/drc_box_unit.sv
module drc_box_unit (
   input  drc_pkg::box_type a,
   input  drc_pkg::box_type b,
   output logic             touch,
   output drc_pkg::box_type merged
);
   import drc_pkg::*;

   always_comb begin
      touch = !(a.x0 > b.x1 || b.x0 > a.x1 || a.y0 > b.y1 || b.y0 > a.y1);
      merged.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
      merged.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
      merged.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
      merged.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
   end

endmodule

FILE: rtl/drc_rect_ram.sv
module drc_rect_ram #(
   parameter int Depth = 64,
   parameter int AddrWidth = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  drc_pkg::box_type     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output drc_pkg::box_type     rd_data
);
   import drc_pkg::*;

   box_type mem [Depth];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/damage_rect_coalescer.sv
// Channel | Direction | Signals
// req     | in        | req_valid, req_ready, req_func, req_rect_x/y/w/h
// rsp     | out       | rsp_valid, rsp_ready, rsp_out_x/y/w/h, last, empty, full
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
// Add, full damage and clear complete in the accepting cycle, so req_ready stays high.
// Emit runs merge passes on one shared compare unit over the rect memory, comparing
// each pair, until a pass merges nothing; then the clip sweep trims rects to the frame
// and drops empty ones, and emit sends each kept rect, holding on output stalls.
// Reset is synchronous, clears the count and the full flag and sets the frame to 640 by 480.
// req_ready is low while an item is in work; a stalled result holds.
module damage_rect_coalescer #(
   parameter int MAX_RECTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic signed [15:0]  req_rect_x,
   input  logic signed [15:0]  req_rect_y,
   input  logic signed [15:0]  req_rect_w,
   input  logic signed [15:0]  req_rect_h,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [14:0]         rsp_out_x,
   output logic [14:0]         rsp_out_y,
   output logic [14:0]         rsp_out_w,
   output logic [14:0]         rsp_out_h,
   output logic                rsp_last,
   output logic                rsp_empty_res,
   output logic                rsp_full_res,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [14:0]         csr_data
);
   import drc_pkg::*;

   localparam int AddrWidth = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int CountWidth = $clog2(MAX_RECTS + 1);
   localparam logic [CountWidth-1:0] CountMax = CountWidth'(MAX_RECTS);
   localparam logic [CountWidth-1:0] CountOne = CountWidth'(1);

   state_type state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic full_ff, full_in, changed_ff, changed_in;
   logic [14:0] fw_ff, fh_ff;
   box_type a_ff, a_in;
   logic rsp_valid_ff, rsp_valid_in, last_ff, last_in, empty_ff, empty_in;
   logic [14:0] ox_ff, ox_in, oy_ff, oy_in, ow_ff, ow_in, oh_ff, oh_in;

   logic wr_en;
   logic [AddrWidth-1:0] wr_addr, rd_addr;
   box_type wr_data, rd_data, merged, clipped;
   logic touch, clip_empty;
   logic signed [EdgeWidth-1:0] fw_s, fh_s;

   drc_rect_ram #(.Depth(MAX_RECTS), .AddrWidth(AddrWidth)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   drc_box_unit u_box (
      .a     (a_ff),
      .b     (rd_data),
      .touch (touch),
      .merged(merged)
   );

   assign fw_s = EdgeWidth'({1'b0, fw_ff});
   assign fh_s = EdgeWidth'({1'b0, fh_ff});

   always_comb begin
      clipped = rd_data;
      if (clipped.x0 < 0) clipped.x0 = '0;
      if (clipped.y0 < 0) clipped.y0 = '0;
      if (clipped.x1 > fw_s) clipped.x1 = fw_s;
      if (clipped.y1 > fh_s) clipped.y1 = fh_s;
      clip_empty = (clipped.x1 <= clipped.x0) || (clipped.y1 <= clipped.y0);
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 15'd640;
         fh_ff <= 15'd480;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  fw_ff <= csr_data;
            CSR_FRAME_HEIGHT: fh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      changed_ff <= changed_in;
      a_ff       <= a_in;
      last_ff    <= last_in;
      empty_ff   <= empty_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      ow_ff      <= ow_in;
      oh_ff      <= oh_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      changed_in   = changed_ff;
      a_in         = a_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      empty_in     = empty_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      ow_in        = ow_ff;
      oh_in        = oh_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = rd_data;
      rd_addr      = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (func_type'(req_func))
                  FUNC_ADD: begin
                     if (req_rect_w > 0 && req_rect_h > 0 && !full_ff) begin
                        wr_en = 1'b1;
                        if (count_ff >= CountMax) begin
                           wr_addr = '0;
                           wr_data = '{'0, '0, fw_s, fh_s};
                           count_in = CountOne;
                           full_in = 1'b1;
                        end else begin
                           wr_addr = count_ff[AddrWidth-1:0];
                           wr_data.x0 = EdgeWidth'(req_rect_x);
                           wr_data.y0 = EdgeWidth'(req_rect_y);
                           wr_data.x1 = EdgeWidth'(req_rect_x) + EdgeWidth'(req_rect_w);
                           wr_data.y1 = EdgeWidth'(req_rect_y) + EdgeWidth'(req_rect_h);
                           count_in = count_ff + CountOne;
                        end
                     end
                  end
                  FUNC_FULL: begin
                     wr_en = 1'b1;
                     wr_addr = '0;
                     wr_data = '{'0, '0, fw_s, fh_s};
                     count_in = CountOne;
                     full_in = 1'b1;
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                     full_in = 1'b0;
                  end
                  default: state_in = ST_PASS_START;
               endcase
            end
         end
         ST_PASS_START: begin
            changed_in = 1'b0;
            i_in = '0;
            state_in = ST_RD_I;
         end
         ST_RD_I: begin
            if (i_ff >= count_ff) begin
               if (changed_ff) begin
                  state_in = ST_PASS_START;
               end else begin
                  i_in = '0;
                  k_in = '0;
                  state_in = ST_CLIP_RD;
               end
            end else begin
               rd_addr = i_ff[AddrWidth-1:0];
               j_in = i_ff + CountOne;
               state_in = ST_LAT_I;
            end
         end
         ST_LAT_I: begin
            a_in = rd_data;
            state_in = ST_RD_J;
         end
         ST_RD_J: begin
            if (j_ff >= count_ff) begin
               wr_en = 1'b1;
               wr_addr = i_ff[AddrWidth-1:0];
               wr_data = a_ff;
               i_in = i_ff + CountOne;
               state_in = ST_RD_I;
            end else begin
               rd_addr = j_ff[AddrWidth-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (touch) begin
               a_in = merged;
               changed_in = 1'b1;
               state_in = ST_RD_LAST;
            end else begin
               j_in = j_ff + CountOne;
               state_in = ST_RD_J;
            end
         end
         ST_RD_LAST: begin
            rd_addr = AddrWidth'(count_ff - CountOne);
            count_in = count_ff - CountOne;
            state_in = ST_WR_LAST;
         end
         ST_WR_LAST: begin
            wr_en = 1'b1;
            wr_addr = j_ff[AddrWidth-1:0];
            wr_data = rd_data;
            state_in = ST_RD_J;
         end
         ST_CLIP_RD: begin
            if (i_ff >= count_ff) begin
               count_in = k_ff;
               i_in = '0;
               if (k_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  ox_in = '0;
                  oy_in = '0;
                  ow_in = '0;
                  oh_in = '0;
                  last_in = 1'b1;
                  empty_in = 1'b1;
                  state_in = ST_EMPTY_OUT;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end else begin
               rd_addr = i_ff[AddrWidth-1:0];
               state_in = ST_CLIP_CHK;
            end
         end
         ST_CLIP_CHK: begin
            if (!clip_empty) begin
               wr_en = 1'b1;
               wr_addr = k_ff[AddrWidth-1:0];
               wr_data = clipped;
               k_in = k_ff + CountOne;
            end
            i_in = i_ff + CountOne;
            state_in = ST_CLIP_RD;
         end
         ST_EMIT_RD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (i_ff >= count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_addr = i_ff[AddrWidth-1:0];
                  state_in = ST_EMIT_OUT;
               end
            end
         end
         ST_EMIT_OUT: begin
            rsp_valid_in = 1'b1;
            ox_in = FieldWidth'(rd_data.x0);
            oy_in = FieldWidth'(rd_data.y0);
            ow_in = FieldWidth'(rd_data.x1 - rd_data.x0);
            oh_in = FieldWidth'(rd_data.y1 - rd_data.y0);
            last_in = (i_ff + CountOne == count_ff);
            empty_in = 1'b0;
            i_in = i_ff + CountOne;
            state_in = ST_EMIT_RD;
         end
         ST_EMPTY_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_out_w     = ow_ff;
   assign rsp_out_h     = oh_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_full_res  = full_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CountMax)
      else $error("Rect count exceeds table depth.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_last))
      else $error("Stalled result changed.");
   assert property (@(posedge clock) disable iff (reset) req_ready |-> !rsp_valid)
      else $error("Input taken while a result is pending.");

endmodule

FILE: test/damage_rect_coalescer_test.sv
module damage_rect_coalescer_test;
   import drc_pkg::*;

   typedef struct {
      int x0;
      int y0;
      int x1;
      int y1;
   } span_box;

   typedef struct {
      logic [14:0] x;
      logic [14:0] y;
      logic [14:0] w;
      logic [14:0] h;
      logic        last;
      logic        empty;
      logic        full;
   } damage_out;

   class damage_board;
      span_box   boxes[64];
      int        box_count;
      bit        full_damage;
      int        frame_w;
      int        frame_h;
      damage_out pending[$];
      int        errors;

      function void reset_state();
         box_count = 0;
         full_damage = 0;
         frame_w = 640;
         frame_h = 480;
         pending.delete();
         errors = 0;
      endfunction

      function void set_frame(csr_index_type idx, logic [14:0] value);
         if (idx == CSR_FRAME_WIDTH) begin
            frame_w = value;
         end else if (idx == CSR_FRAME_HEIGHT) begin
            frame_h = value;
         end
      endfunction

      function void go_full();
         boxes[0] = '{0, 0, frame_w, frame_h};
         box_count = 1;
         full_damage = 1;
      endfunction

      function bit boxes_touch(span_box a, span_box b);
         return !(a.x0 > b.x1 || b.x0 > a.x1 || a.y0 > b.y1 || b.y0 > a.y1);
      endfunction

      function void coalesce();
         bit changed;
         int j;
         span_box a;
         span_box b;
         changed = 1;
         while (changed) begin
            changed = 0;
            for (int i = 0; i < box_count; i++) begin
               j = i + 1;
               while (j < box_count) begin
                  a = boxes[i];
                  b = boxes[j];
                  if (boxes_touch(a, b)) begin
                     boxes[i].x0 = a.x0 < b.x0 ? a.x0 : b.x0;
                     boxes[i].y0 = a.y0 < b.y0 ? a.y0 : b.y0;
                     boxes[i].x1 = a.x1 > b.x1 ? a.x1 : b.x1;
                     boxes[i].y1 = a.y1 > b.y1 ? a.y1 : b.y1;
                     boxes[j] = boxes[box_count - 1];
                     box_count--;
                     changed = 1;
                  end else begin
                     j++;
                  end
               end
            end
         end
      endfunction

      function void note_request(func_type f, logic signed [15:0] x, logic signed [15:0] y,
                                 logic signed [15:0] w, logic signed [15:0] h);
         span_box r;
         int kept;
         damage_out o;
         case (f)
            FUNC_ADD: begin
               if (w > 0 && h > 0 && !full_damage) begin
                  if (box_count >= 64) begin
                     go_full();
                  end else begin
                     boxes[box_count] = '{int'(x), int'(y), int'(x) + int'(w),
                                          int'(y) + int'(h)};
                     box_count++;
                  end
               end
            end
            FUNC_FULL: go_full();
            FUNC_CLEAR: begin
               box_count = 0;
               full_damage = 0;
            end
            default: begin
               coalesce();
               kept = 0;
               for (int i = 0; i < box_count; i++) begin
                  r = boxes[i];
                  if (r.x0 < 0) r.x0 = 0;
                  if (r.y0 < 0) r.y0 = 0;
                  if (r.x1 > frame_w) r.x1 = frame_w;
                  if (r.y1 > frame_h) r.y1 = frame_h;
                  if (r.x1 > r.x0 && r.y1 > r.y0) begin
                     boxes[kept] = r;
                     kept++;
                  end
               end
               box_count = kept;
               if (box_count == 0) begin
                  o = '{0, 0, 0, 0, 1, 1, full_damage};
                  pending.push_back(o);
               end
               for (int i = 0; i < box_count; i++) begin
                  o.x = boxes[i].x0[14:0];
                  o.y = boxes[i].y0[14:0];
                  o.w = 15'(boxes[i].x1 - boxes[i].x0);
                  o.h = 15'(boxes[i].y1 - boxes[i].y0);
                  o.last = (i + 1 == box_count);
                  o.empty = 0;
                  o.full = full_damage;
                  pending.push_back(o);
               end
            end
         endcase
      endfunction

      function void check_result(damage_out got);
         damage_out e;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, got.x);
            errors++;
         end
         if (got.y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, got.y);
            errors++;
         end
         if (got.w !== e.w) begin
            $error("out_w expected %0d actual %0d", e.w, got.w);
            errors++;
         end
         if (got.h !== e.h) begin
            $error("out_h expected %0d actual %0d", e.h, got.h);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last expected %0d actual %0d", e.last, got.last);
            errors++;
         end
         if (got.empty !== e.empty) begin
            $error("empty_res expected %0d actual %0d", e.empty, got.empty);
            errors++;
         end
         if (got.full !== e.full) begin
            $error("full_res expected %0d actual %0d", e.full, got.full);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_func;
   logic signed [15:0] req_rect_x;
   logic signed [15:0] req_rect_y;
   logic signed [15:0] req_rect_w;
   logic signed [15:0] req_rect_h;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [14:0]        rsp_out_x;
   logic [14:0]        rsp_out_y;
   logic [14:0]        rsp_out_w;
   logic [14:0]        rsp_out_h;
   logic               rsp_last;
   logic               rsp_empty_res;
   logic               rsp_full_res;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [14:0]        csr_data;

   damage_board board;
   bit          hold_off;
   int          burst_left;

   damage_rect_coalescer dut (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #400000000;
      $display("damage_rect_coalescer_test NOT OK");
      $finish;
   end

   // The receiver stalls at random, with a long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      damage_out got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_x, rsp_out_y, rsp_out_w, rsp_out_h, rsp_last, rsp_empty_res,
                 rsp_full_res};
         board.check_result(got);
      end
   end

   task automatic send_request(func_type f, logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] w, logic signed [15:0] h);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid = 1'b1;
      req_func = f;
      req_rect_x = x;
      req_rect_y = y;
      req_rect_w = w;
      req_rect_h = h;
      do @(posedge clock); while (!req_ready);
      board.note_request(f, x, y, w, h);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_frame(csr_index_type idx, logic [14:0] value);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_frame(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_add(int span);
      send_request(FUNC_ADD, 16'($urandom_range(0, span) - span / 4),
                   16'($urandom_range(0, span) - span / 4),
                   16'($urandom_range(1, span / 3 + 1)),
                   16'($urandom_range(1, span / 3 + 1)));
   endtask

   task automatic random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         random_add(700);
      end else if (pick < 78) begin
         send_request(FUNC_ADD, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 92) begin
         send_request(FUNC_EMIT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (pick < 96) begin
         send_request(FUNC_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         send_request(FUNC_FULL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      board = new();
      board.reset_state();
      hold_off = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_ADD;
      req_rect_x = '0;
      req_rect_y = '0;
      req_rect_w = '0;
      req_rect_h = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FRAME_WIDTH;
      csr_data = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      send_request(FUNC_EMIT, 0, 0, 0, 0);
      send_request(FUNC_ADD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
      send_request(FUNC_ADD, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_request(FUNC_ADD, 10, 10, 0, 5);
      send_request(FUNC_ADD, 10, 10, 5, -16'sd32768);
      send_request(FUNC_ADD, 100, 100, 10, 10);
      send_request(FUNC_ADD, 110, 100, 10, 10);
      send_request(FUNC_ADD, 300, 300, 5, 5);
      send_request(FUNC_ADD, 700, 10, 5, 5);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      send_request(FUNC_FULL, 0, 0, 0, 0);
      send_request(FUNC_ADD, 1, 1, 1, 1);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      send_request(FUNC_CLEAR, 0, 0, 0, 0);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      for (int i = 0; i < 65; i++) begin
         send_request(FUNC_ADD, 16'((i % 8) * 80), 16'((i / 8) * 60), 20, 20);
      end
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      send_request(FUNC_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 40; i++) begin
         send_request(FUNC_ADD, 16'((i % 8) * 80), 16'((i / 8) * 90), 20, 20);
      end
      fork
         begin
            hold_off = 1;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end
         begin
            send_request(FUNC_EMIT, 0, 0, 0, 0);
            for (int i = 0; i < 6; i++) random_add(700);
         end
      join

      send_request(FUNC_FULL, 0, 0, 0, 0);
      write_frame(CSR_FRAME_WIDTH, 15'd32767);
      write_frame(CSR_FRAME_HEIGHT, 15'd32767);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      send_request(FUNC_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < 120; i++) random_request();
      send_request(FUNC_CLEAR, 0, 0, 0, 0);
      send_request(FUNC_ADD, 5, 5, 10, 10);
      write_frame(CSR_FRAME_WIDTH, 15'd0);
      write_frame(CSR_FRAME_HEIGHT, 15'd1);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      write_frame(CSR_FRAME_WIDTH, 15'd1);
      write_frame(CSR_FRAME_HEIGHT, 15'd0);
      send_request(FUNC_ADD, 0, 0, 10, 10);
      send_request(FUNC_EMIT, 0, 0, 0, 0);
      write_frame(CSR_FRAME_WIDTH, 15'd320);
      write_frame(CSR_FRAME_HEIGHT, 15'd240);
      for (int i = 0; i < 130; i++) random_request();
      write_frame(CSR_FRAME_WIDTH, 15'($urandom_range(1, 32767)));
      write_frame(CSR_FRAME_HEIGHT, 15'($urandom_range(1, 32767)));
      for (int i = 0; i < 100; i++) random_request();
      send_request(FUNC_EMIT, 0, 0, 0, 0);

      while (board.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (board.errors == 0) begin
         $display("damage_rect_coalescer_test OK");
      end else begin
         $display("damage_rect_coalescer_test NOT OK");
      end
      $finish;
   end
endmodule
